// ===== hw/rtl/cbs_pkg.sv =====
`timescale 1ns / 1ps
package cbs_pkg;

    localparam int CBS_BYTE_W   = 8;
    localparam int CBS_COEF_W   = 12;
    localparam int CBS_ETA_W    = 3;
    localparam int CBS_LEN_W    = 9;
    localparam int CBS_BUF_W    = 15;
    localparam int CBS_HELD_W   = 4;
    localparam int CBS_IDX_W    = 2;
    localparam int CBS_IN_DEPTH  = 2;
    localparam int CBS_OUT_DEPTH = 2;

    localparam logic [CBS_COEF_W-1:0] CBS_MODULUS    = 12'd3329;
    localparam logic [CBS_LEN_W-1:0]  CBS_MAX_COEFFS = 9'd256;

    localparam logic [CBS_ETA_W-1:0]  CBS_ETA_RESET  = 3'd2;
    localparam logic [CBS_ETA_W-1:0]  CBS_ETA_MAX    = 3'd4;
    localparam logic [CBS_LEN_W-1:0]  CBS_LEN_RESET  = 9'd256;

    localparam logic [CBS_IDX_W-1:0] REG_ETA         = 2'd0;
    localparam logic [CBS_IDX_W-1:0] REG_POLY_LENGTH = 2'd1;

    typedef struct packed {
        logic [CBS_ETA_W-1:0] eta;
        logic [CBS_LEN_W-1:0] len;
    } t_cfg;

    function automatic logic [2:0] cbs_ones(input logic [3:0] v);
        logic [2:0] c;
        c = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
        return c;
    endfunction

    function automatic logic [3:0] cbs_eta_mask(input logic [CBS_ETA_W-1:0] e);
        logic [3:0] m;
        case (e)
            3'd1: m = 4'b0001;
            3'd2: m = 4'b0011;
            3'd3: m = 4'b0111;
            default: m = 4'b1111;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/centered_binomial_sampler_core.sv =====
`timescale 1ns / 1ps
// Centered binomial sampler: random bytes go in through a small byte queue and are
// consumed LSB first; each coefficient uses 2*eta bits and is (ones in first eta bits
// minus ones in next eta bits) mod 3329. The unpack stage draws one coefficient per
// cycle while the result queue has room, and refills its 15-bit bit buffer with the
// next byte in the same cycle once fewer than 2*eta bits remain. The result queue
// delivers up to one coefficient per cycle. last marks the final coefficient of each
// poly_length run; the rest of the bits held then are dropped. Any write to eta or
// poly_length restarts the polynomial; write only while idle.
module centered_binomial_sampler_core
    import cbs_pkg::*;
#(
    parameter int IN_DEPTH  = CBS_IN_DEPTH,
    parameter int OUT_DEPTH = CBS_OUT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [CBS_BYTE_W-1:0] i_random_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [CBS_COEF_W-1:0] o_coefficient,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CBS_IDX_W-1:0]  i_cfg_index,
    input  logic [CBS_LEN_W-1:0]  i_cfg_data
);

    t_cfg                  r_cfg, n_cfg;
    logic                  w_restart;
    logic                  w_byte_empty;
    logic [CBS_BYTE_W-1:0] w_byte;
    logic                  w_byte_take;
    logic                  w_res_push;
    logic [CBS_COEF_W-1:0] w_res_coef;
    logic                  w_res_last;
    logic                  w_res_full;
    logic [CBS_ETA_W-1:0]  w_eta_raw;
    logic [CBS_LEN_W-1:0]  w_len_raw;

    assign o_cfg_ready = 1'b1;
    assign w_eta_raw   = i_cfg_data[CBS_ETA_W-1:0];
    assign w_len_raw   = i_cfg_data;
    assign w_restart   = i_cfg_valid &&
                         (i_cfg_index == REG_ETA || i_cfg_index == REG_POLY_LENGTH);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ETA: begin
                    if (w_eta_raw == '0) begin
                        n_cfg.eta = 3'd1;
                    end else if (w_eta_raw > CBS_ETA_MAX) begin
                        n_cfg.eta = CBS_ETA_MAX;
                    end else begin
                        n_cfg.eta = w_eta_raw;
                    end
                end
                REG_POLY_LENGTH: begin
                    if (w_len_raw == '0) begin
                        n_cfg.len = 9'd1;
                    end else if (w_len_raw > CBS_MAX_COEFFS) begin
                        n_cfg.len = CBS_MAX_COEFFS;
                    end else begin
                        n_cfg.len = w_len_raw;
                    end
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eta <= CBS_ETA_RESET;
            r_cfg.len <= CBS_LEN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    cbs_fifo #(
        .WIDTH (CBS_BYTE_W),
        .DEPTH (IN_DEPTH)
    ) u_in_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_random_byte),
        .o_full  (full),
        .i_pop   (w_byte_take),
        .o_data  (w_byte),
        .o_empty (w_byte_empty)
    );

    cbs_unpack u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_restart    (w_restart),
        .i_byte_valid (!w_byte_empty),
        .i_byte       (w_byte),
        .o_byte_take  (w_byte_take),
        .o_res_push   (w_res_push),
        .o_res_coef   (w_res_coef),
        .o_res_last   (w_res_last),
        .i_res_full   (w_res_full)
    );

    cbs_fifo #(
        .WIDTH (CBS_COEF_W + 1),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  ({w_res_last, w_res_coef}),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  ({o_last, o_coefficient}),
        .o_empty (empty)
    );

endmodule

// ===== hw/rtl/cbs_fifo.sv =====
`timescale 1ns / 1ps
module cbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/cbs_unpack.sv =====
`timescale 1ns / 1ps
module cbs_unpack
    import cbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_restart,
    input  logic                  i_byte_valid,
    input  logic [CBS_BYTE_W-1:0] i_byte,
    output logic                  o_byte_take,
    output logic                  o_res_push,
    output logic [CBS_COEF_W-1:0] o_res_coef,
    output logic                  o_res_last,
    input  logic                  i_res_full
);

    logic [CBS_BUF_W-1:0]  r_buf, n_buf;
    logic [CBS_HELD_W-1:0] r_held, n_held;
    logic [CBS_LEN_W-1:0]  r_cnt, n_cnt;

    logic [CBS_HELD_W-1:0] w_group;
    logic [3:0]            w_mask;
    logic [2:0]            w_a, w_b;
    logic                  w_emit;
    logic                  w_is_last;
    logic [CBS_LEN_W:0]    w_cnt_inc;
    logic [CBS_BUF_W-1:0]  w_post_buf;
    logic [CBS_HELD_W-1:0] w_post_held;
    logic [CBS_LEN_W-1:0]  w_post_cnt;
    logic                  w_take;

    assign w_group   = {i_cfg.eta, 1'b0};
    assign w_mask    = cbs_eta_mask(i_cfg.eta);
    assign w_a       = cbs_ones(r_buf[3:0] & w_mask);
    assign w_b       = cbs_ones(4'(r_buf >> i_cfg.eta) & w_mask);
    assign w_emit    = (r_held >= w_group) && !i_res_full;
    assign w_cnt_inc = {1'b0, r_cnt} + 1'b1;
    assign w_is_last = (w_cnt_inc >= {1'b0, i_cfg.len});

    assign o_res_push = w_emit;
    assign o_res_last = w_is_last;
    // negative difference wraps into the upper end of the field
    assign o_res_coef = (w_a >= w_b) ? CBS_COEF_W'(w_a - w_b)
                                     : CBS_MODULUS - CBS_COEF_W'(w_b - w_a);

    always_comb begin
        w_post_buf  = r_buf;
        w_post_held = r_held;
        w_post_cnt  = r_cnt;
        if (w_emit) begin
            if (w_is_last) begin
                // leftover bits of the polynomial are dropped
                w_post_buf  = '0;
                w_post_held = '0;
                w_post_cnt  = '0;
            end else begin
                w_post_buf  = r_buf >> w_group;
                w_post_held = r_held - w_group;
                w_post_cnt  = w_cnt_inc[CBS_LEN_W-1:0];
            end
        end
    end

    // refill in the same cycle as a draw once the remainder cannot form a group
    assign w_take      = i_byte_valid && (w_post_held < w_group) && !i_restart;
    assign o_byte_take = w_take;

    always_comb begin
        n_buf  = w_post_buf;
        n_held = w_post_held;
        n_cnt  = w_post_cnt;
        if (w_take) begin
            n_buf  = w_post_buf | (CBS_BUF_W'(i_byte) << w_post_held);
            n_held = w_post_held + CBS_HELD_W'(CBS_BYTE_W);
        end
        if (i_restart) begin
            n_buf  = '0;
            n_held = '0;
            n_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_held <= '0;
            r_cnt  <= '0;
        end else begin
            r_buf  <= n_buf;
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < i_cfg.len)
        else $error("coefficient count reached polynomial length");

    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (o_res_coef <= 12'd4 || o_res_coef >= 12'd3325))
        else $error("coefficient outside binomial range");

    a_refill_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_held >= CBS_HELD_W'(CBS_BYTE_W)))
        else $error("bit count lost after byte refill");

endmodule
